>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the page run allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define PRA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("page run allocator assertion failed");
// Condition never holds outside reset.
`define PRA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("page run allocator forbidden condition");
`else
`define PRA_ASSERT(lbl, clk, rst_n, prop)
`define PRA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/pra_pkg.sv
// Types and codes shared by the page run allocator modules.
package pra_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] page_count;
		logic [8:0] start_page;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [8:0] base_page;
	} res_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_SWEEP
	} state_t;

	// What the address/count walker is doing.
	typedef enum logic [1:0] {
		WK_SWEEP,
		WK_FREE,
		WK_MARK,
		WK_SCAN
	} walk_t;

	typedef enum logic [1:0] {
		RP_FAIL,
		RP_OK,
		RP_ALLOC,
		RP_FREE
	} reply_t;

	typedef struct packed {
		logic   load;
		logic   setup;
		logic   step;
		walk_t  kind;
		logic   reply;
		reply_t rsel;
	} ctl_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       left_zero;
		logic       chk_v;
		logic       hit;
		logic       alloc_bad;
	} st_t;

endpackage

>>> hw/rtl/pra_ctrl.sv
// Controller state machine for the page run allocator.
`include "assert_macros.svh"
module pra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pra_pkg::st_t  st,
	output pra_pkg::ctl_t ctl,
	output logic          busy
);

	pra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pra_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pra_pkg::ST_INIT: begin
				if (st.left_zero) state_d = pra_pkg::ST_IDLE;
			end
			pra_pkg::ST_IDLE: begin
				if (start) state_d = pra_pkg::ST_DECODE;
			end
			pra_pkg::ST_DECODE: begin
				case (st.opcode)
					pra_pkg::OP_ALLOC: state_d = st.alloc_bad ? pra_pkg::ST_IDLE
						: pra_pkg::ST_SCAN;
					pra_pkg::OP_FREE:  state_d = pra_pkg::ST_FREE;
					pra_pkg::OP_CLEAR: state_d = pra_pkg::ST_SWEEP;
					default:           state_d = pra_pkg::ST_IDLE;
				endcase
			end
			pra_pkg::ST_SCAN: begin
				if (st.hit) state_d = pra_pkg::ST_MARK;
				else if (st.left_zero && !st.chk_v) state_d = pra_pkg::ST_IDLE;
			end
			pra_pkg::ST_MARK, pra_pkg::ST_FREE, pra_pkg::ST_SWEEP: begin
				if (st.left_zero) state_d = pra_pkg::ST_IDLE;
			end
			default: state_d = pra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.kind = pra_pkg::WK_SWEEP;
		ctl.rsel = pra_pkg::RP_FAIL;
		case (state_q)
			pra_pkg::ST_INIT: begin
				ctl.step = !st.left_zero;
			end
			pra_pkg::ST_IDLE: begin
				ctl.load = start;
			end
			pra_pkg::ST_DECODE: begin
				case (st.opcode)
					pra_pkg::OP_ALLOC: begin
						if (st.alloc_bad) begin
							ctl.reply = 1'b1;
						end else begin
							ctl.setup = 1'b1;
							ctl.kind  = pra_pkg::WK_SCAN;
						end
					end
					pra_pkg::OP_FREE: begin
						ctl.setup = 1'b1;
						ctl.kind  = pra_pkg::WK_FREE;
					end
					pra_pkg::OP_CLEAR: begin
						ctl.setup = 1'b1;
					end
					default: ctl.reply = 1'b1;
				endcase
			end
			pra_pkg::ST_SCAN: begin
				if (st.hit) begin
					ctl.setup = 1'b1;
					ctl.kind  = pra_pkg::WK_MARK;
				end else if (st.left_zero && !st.chk_v) begin
					ctl.reply = 1'b1;
				end else begin
					ctl.step = !st.left_zero;
					ctl.kind = pra_pkg::WK_SCAN;
				end
			end
			pra_pkg::ST_MARK: begin
				ctl.kind  = pra_pkg::WK_MARK;
				ctl.reply = st.left_zero;
				ctl.step  = !st.left_zero;
				ctl.rsel  = pra_pkg::RP_ALLOC;
			end
			pra_pkg::ST_FREE: begin
				ctl.kind  = pra_pkg::WK_FREE;
				ctl.reply = st.left_zero;
				ctl.step  = !st.left_zero;
				ctl.rsel  = pra_pkg::RP_FREE;
			end
			pra_pkg::ST_SWEEP: begin
				ctl.reply = st.left_zero;
				ctl.step  = !st.left_zero;
				ctl.rsel  = pra_pkg::RP_OK;
			end
			default: ctl = '0;
		endcase
	end

	assign busy = (state_q != pra_pkg::ST_IDLE);

	`PRA_NEVER(a_setup_and_step, clk, arst_n, ctl.setup && ctl.step)
	`PRA_ASSERT(a_reply_to_idle, clk, arst_n, ctl.reply |=> (state_q == pra_pkg::ST_IDLE))
	`PRA_ASSERT(a_accept_decodes, clk, arst_n,
		(state_q == pra_pkg::ST_IDLE && start) |=> (state_q == pra_pkg::ST_DECODE))

endmodule

>>> hw/rtl/pra_dp.sv
// Datapath for the page run allocator: page map memory, walker and run counter.
`include "assert_macros.svh"
module pra_dp #(
	parameter int NUM_PAGES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pra_pkg::cmd_t cmd,
	input  pra_pkg::ctl_t ctl,
	output pra_pkg::st_t  st,
	output pra_pkg::res_t res,
	output logic          done
);

	localparam int AW = $clog2(NUM_PAGES);
	localparam int CB = $clog2(NUM_PAGES + 1);
	// Wide enough for start_page + page_count and for the page count itself.
	localparam int EW = (CB > 11) ? CB : 11;
	localparam logic [EW-1:0] NP = EW'(NUM_PAGES);

	logic          mem_q [NUM_PAGES];
	pra_pkg::cmd_t cmd_q;
	logic [AW-1:0] addr_q;
	logic [EW-1:0] left_q;
	logic [EW-1:0] run_q;
	logic [AW-1:0] base_q;
	logic          chk_v_s1;
	logic [AW-1:0] chk_addr_s1;
	logic          used_s1;
	pra_pkg::res_t res_q;
	logic          done_q;

	logic [EW-1:0] want, first, free_end, free_len, run_nx, setup_left;
	logic [AW-1:0] setup_addr;
	logic          free_ok, alloc_bad, hit, left_zero, wen, ren;

	always_comb begin
		want      = EW'(cmd_q.page_count);
		first     = EW'(cmd_q.start_page);
		free_end  = first + EW'(cmd_q.page_count);
		free_ok   = (free_end <= NP);
		// pages of the free run that lie inside the map
		if (first >= NP) free_len = '0;
		else if (free_ok) free_len = want;
		else free_len = NP - first;
		alloc_bad = (want == '0) || (want > NP);
		run_nx    = run_q + EW'(1);
		hit       = chk_v_s1 && !used_s1 && (run_nx == want);
		left_zero = (left_q == '0);
		ren       = ctl.step && (ctl.kind == pra_pkg::WK_SCAN) && !left_zero;
		wen       = ctl.step && (ctl.kind != pra_pkg::WK_SCAN) && !left_zero;
	end

	always_comb begin
		case (ctl.kind)
			pra_pkg::WK_SWEEP: begin
				setup_addr = '0;
				setup_left = NP;
			end
			pra_pkg::WK_FREE: begin
				setup_addr = AW'(first);
				setup_left = free_len;
			end
			pra_pkg::WK_MARK: begin
				setup_addr = chk_addr_s1;
				setup_left = want;
			end
			pra_pkg::WK_SCAN: begin
				setup_addr = AW'(NUM_PAGES - 1);
				setup_left = NP;
			end
			default: begin
				setup_addr = '0;
				setup_left = '0;
			end
		endcase
	end

	// Out of reset the walker is set for the initial map sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			left_q   <= NP;
			run_q    <= '0;
			chk_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			chk_v_s1 <= ren;
			done_q   <= ctl.reply;
			if (ctl.setup) begin
				addr_q <= setup_addr;
				left_q <= setup_left;
			end else if (ctl.step && !left_zero) begin
				left_q <= left_q - EW'(1);
				addr_q <= (ctl.kind == pra_pkg::WK_SCAN) ? addr_q - AW'(1) : addr_q + AW'(1);
			end
			if (ctl.setup) run_q <= '0;
			else if (chk_v_s1) run_q <= used_s1 ? '0 : run_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) mem_q[addr_q] <= (ctl.kind == pra_pkg::WK_MARK);
		if (ren) begin
			used_s1     <= mem_q[addr_q];
			chk_addr_s1 <= addr_q;
		end
		if (ctl.load) cmd_q <= cmd;
		if (ctl.setup && ctl.kind == pra_pkg::WK_MARK) base_q <= chk_addr_s1;
		if (ctl.reply) begin
			case (ctl.rsel)
				pra_pkg::RP_FAIL:  res_q <= '{ok: 1'b0, base_page: 9'd0};
				pra_pkg::RP_OK:    res_q <= '{ok: 1'b1, base_page: 9'd0};
				pra_pkg::RP_ALLOC: res_q <= '{ok: 1'b1, base_page: 9'(base_q)};
				pra_pkg::RP_FREE:  res_q <= '{ok: free_ok, base_page: 9'd0};
				default:           res_q <= '{ok: 1'b0, base_page: 9'd0};
			endcase
		end
	end

	assign st.opcode    = cmd_q.opcode;
	assign st.left_zero = left_zero;
	assign st.chk_v     = chk_v_s1;
	assign st.hit       = hit;
	assign st.alloc_bad = alloc_bad;
	assign res          = res_q;
	assign done         = done_q;

	`PRA_NEVER(a_rd_wr_clash, clk, arst_n, wen && ren)
	`PRA_ASSERT(a_wr_in_run, clk, arst_n, wen |-> (left_q != '0))
	`PRA_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q)

endmodule

>>> hw/rtl/page_run_allocator_top_down_top.sv
// Top level of the top-down first-fit page run allocator.
//
//  channel   ports                     handshake
//  command   start, busy, cmd          word taken when start && !busy
//  result    done, res                 one-cycle strobe, always taken
//
// One result word per command. Allocate reads the map one page per cycle from the top;
// a bad size or opcode fails without a walk. Free walks the pages inside the map; clear, the whole map.
// After reset busy stays high while the map is swept clear.
// The result side has no stall; a word shows on res for the single cycle of done.
module page_run_allocator_top_down_top #(
	parameter int NUM_PAGES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pra_pkg::cmd_t cmd,
	output logic          done,
	output pra_pkg::res_t res
);

	pra_pkg::ctl_t ctl;
	pra_pkg::st_t  st;

	pra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	pra_dp #(
		.NUM_PAGES (NUM_PAGES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.st     (st),
		.res    (res),
		.done   (done)
	);

endmodule

>>> verif/testbench.sv
// Testbench for the top-down page run allocator: directed edge cases, then random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pra_pkg::*;

	localparam int NUM_PAGES = 512;
	// watchdog limit; this leaves a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	res_t res;

	page_run_allocator_top_down_top #(
		.NUM_PAGES(NUM_PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res)
	);

	bit page_used_m [NUM_PAGES];
	res_t pending_res [$];
	int err_cnt = 0;
	int cycle_cnt;
	bit no_gaps = 1'b0;
	// runs handed out so far, so frees can target real runs
	int run_base [$];
	int run_len [$];

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("tb: mismatch at %0t: %s", $realtime, msg);
	endtask

	// Page map model: applies one command word and returns the result word it should give.
	task automatic model_cmd(input cmd_t c, output res_t r);
		int run;
		int stop;
		r = '0;
		case (c.opcode)
		OP_ALLOC: begin
			run = 0;
			if (c.page_count != 0 && int'(c.page_count) <= NUM_PAGES) begin
				for (int p = NUM_PAGES - 1; p >= 0; p--) begin
					if (page_used_m[p])
						run = 0;
					else
						run++;
					if (run == int'(c.page_count)) begin
						for (int k = p; k < p + run; k++)
							page_used_m[k] = 1'b1;
						r.ok = 1'b1;
						r.base_page = 9'(p);
						break;
					end
				end
			end
		end
		OP_FREE: begin
			stop = int'(c.start_page) + int'(c.page_count);
			for (int p = int'(c.start_page); p < stop && p < NUM_PAGES; p++)
				page_used_m[p] = 1'b0;
			r.ok = (stop <= NUM_PAGES);
		end
		OP_CLEAR: begin
			foreach (page_used_m[p])
				page_used_m[p] = 1'b0;
			r.ok = 1'b1;
		end
		default: begin
			r.ok = 1'b0;
		end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 92)
			return $urandom_range(9, 64);
		else if (r < 99)
			return $urandom_range(65, 300);
		return $urandom_range(301, NUM_PAGES);
	endfunction

	task automatic hold_off(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// start is left high on return when no gap follows, so the next word goes back to back
	task automatic send_cmd(input logic [1:0] op, input int count, input int first,
			output res_t r);
		cmd_t c;
		c.opcode = op;
		c.page_count = 10'(count);
		c.start_page = 9'(first);
		cmd <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		model_cmd(c, r);
		pending_res.push_back(r);
		if (!no_gaps)
			hold_off(pick_gap());
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		res_t want_w;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending ok=%0b base=%0d",
					res.ok, res.base_page));
			end else begin
				want_w = pending_res.pop_front();
				if (res.ok !== want_w.ok)
					report_mismatch($sformatf("ok got %0b want %0b", res.ok, want_w.ok));
				if (res.base_page !== want_w.base_page)
					report_mismatch($sformatf("base_page got %0d want %0d",
						res.base_page, want_w.base_page));
			end
		end
	end

	task automatic test_extremes();
		res_t r;
		send_cmd(OP_ALLOC, 0, 511, r);            // zero length fails
		send_cmd(OP_ALLOC, NUM_PAGES + 1, 0, r);  // longer than the map
		send_cmd(OP_ALLOC, 1023, 0, r);
		send_cmd(OP_ALLOC, NUM_PAGES, 0, r);      // whole map
		send_cmd(OP_ALLOC, 1, 0, r);              // map full
		send_cmd(OP_FREE, NUM_PAGES, 0, r);
		send_cmd(OP_ALLOC, 1, 0, r);
		send_cmd(OP_ALLOC, NUM_PAGES - 1, 0, r);
		send_cmd(OP_FREE, 2, 511, r);             // runs past the end
		send_cmd(OP_FREE, 0, 0, r);
		send_cmd(OP_FREE, 0, 511, r);
		send_cmd(OP_FREE, 1023, 300, r);
		send_cmd(OP_UNUSED, 1023, 511, r);
		send_cmd(OP_ALLOC, 212, 0, r);
		send_cmd(OP_CLEAR, 1023, 511, r);
		send_cmd(OP_ALLOC, 3, 0, r);
		send_cmd(OP_ALLOC, 2, 0, r);
		send_cmd(OP_FREE, 3, 509, r);
		send_cmd(OP_ALLOC, 4, 0, r);              // top gap too short, run restarts
		send_cmd(OP_ALLOC, 3, 0, r);
		send_cmd(OP_UNUSED, 0, 0, r);
		send_cmd(OP_FREE, NUM_PAGES, 0, r);
		send_cmd(OP_ALLOC, NUM_PAGES, 511, r);
		send_cmd(OP_CLEAR, 0, 0, r);
	endtask

	task automatic test_pause_until_drained();
		res_t r;
		for (int i = 0; i < 4; i++)
			send_cmd(OP_ALLOC, $urandom_range(1, 16), $urandom_range(0, 511), r);
		wait_drained();
		send_cmd(OP_FREE, 8, NUM_PAGES - 8, r);
		send_cmd(OP_ALLOC, 4, 0, r);
		wait_drained();
		send_cmd(OP_CLEAR, 0, 0, r);
	endtask

	task automatic random_item();
		res_t r;
		int sel;
		int idx;
		int len;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			len = pick_len();
			send_cmd(OP_ALLOC, len, $urandom_range(0, 511), r);
			if (r.ok) begin
				run_base.push_back(int'(r.base_page));
				run_len.push_back(len);
			end
		end else if (sel < 80 && run_base.size() != 0) begin
			idx = $urandom_range(0, run_base.size() - 1);
			send_cmd(OP_FREE, run_len[idx], run_base[idx], r);
			run_base.delete(idx);
			run_len.delete(idx);
		end else if (sel < 90) begin
			// stray free, mostly short
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 16);
			send_cmd(OP_FREE, len, $urandom_range(0, 511), r);
		end else if (sel < 94) begin
			send_cmd(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 511), r);
			run_base.delete();
			run_len.delete();
		end else if (sel < 97) begin
			send_cmd(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 511), r);
		end else begin
			len = $urandom_range(0, 1) ? 0 : $urandom_range(NUM_PAGES + 1, 1023);
			send_cmd(OP_ALLOC, len, $urandom_range(0, 511), r);
		end
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++) begin
			// bursts of back-to-back words
			if (i % 100 == 50)
				no_gaps = 1'b1;
			else if (i % 100 == 90)
				no_gaps = 1'b0;
			random_item();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_pause_until_drained();
		test_random_traffic(500);
		wait_drained();
		repeat (2 * NUM_PAGES + 16) @(posedge clk);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
